// ===== design/ert_pkg.sv =====
package ert_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SEND  = 2'd1,
        OP_REPLY = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [2:0] ST_UNSENT  = 3'd0;
    localparam logic [2:0] ST_SENT    = 3'd1;
    localparam logic [2:0] ST_RECVD   = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_ERROR   = 3'd4;

    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    localparam logic [1:0] REG_PACKET_COUNT  = 2'd0;
    localparam logic [1:0] REG_SEND_INTERVAL = 2'd1;
    localparam logic [1:0] REG_TIMEOUT       = 2'd2;

    localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
    localparam logic [7:0] TYPE3  = 8'd3;
    localparam logic [7:0] TYPE5  = 8'd5;
    localparam logic [7:0] TYPE11 = 8'd11;
    localparam logic [7:0] TYPE12 = 8'd12;

    localparam logic [10:0] TAG_BYTES_MIN = 11'd24;
    localparam logic [10:0] HDR_BYTES_MIN = 11'd8;

    localparam int IN_BITS  = 2 + 64 + 64 + 16 + 8 + 8 + 11 + 4;
    localparam int IN_BYTES = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = 1 + 1 + 1 + 4 + 3 + 32 + 2 + 5 + 1 + 1;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

endpackage

// ===== design/echo_request_tracker.sv =====
// Channel   | Direction | Word
// s_axis    | in        | tdata: op, guid_high, guid_low, reply_seq, icmp_type,
//           |           |        icmp_code, msg_len, entry_select
// m_axis    | out       | tdata: accepted, matched, seq_only, entry_index,
//           |           |        entry_state, round_trip, reply_kind,
//           |           |        newly_timed_out, pending, finished
// cfg       | in        | cfg_index, cfg_data (register writes)
//
// One word at a time. Tick and error-by-tag words scan the entry memories,
// one entry a cycle. Other words step through reading the memory, writing
// back and computing, reading the result times, loading the result and
// returning to idle.
// Reset clears status flags in flops; tag/time memories stay unset.
// A result waits in an output register; the next word is taken while it
// waits, but a new result is held back until the old one is taken.
module echo_request_tracker #(
    parameter int ENTRIES   = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // op[1:0], guid_high[65:2], guid_low[129:66], reply_seq[145:130],
    // icmp_type[153:146], icmp_code[161:154], msg_len[172:162],
    // entry_select[176:173]
    input  logic [ert_pkg::IN_BYTES*8-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // accepted[0], matched[1], seq_only[2], entry_index[6:3],
    // entry_state[9:7], round_trip[41:10], reply_kind[43:42],
    // newly_timed_out[48:44], pending[49], finished[50]
    output logic [ert_pkg::OUT_BYTES*8-1:0] m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);
    import ert_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_SCAN, S_SCAN_LAST, S_WAIT, S_DONE
    } state_t;

    // configuration
    logic [4:0]  packet_count_reg;
    logic [15:0] send_interval_reg;
    logic [15:0] timeout_reg;

    // control state
    state_t               state_reg;
    logic [TIME_BITS-1:0] time_now_reg;
    logic [TIME_BITS-1:0] next_send_reg;
    logic [CW-1:0]        next_index_reg;
    logic [2:0]           status_reg [ENTRIES];
    logic [4:0]           timed_reg;
    logic                 found_reg;

    // captured word
    op_t         op_reg;
    logic [63:0] ghi_reg, glo_reg;
    logic [15:0] seq_reg;
    logic [7:0]  typ_reg, code_reg;
    logic [10:0] len_reg;
    logic [3:0]  sel_reg;

    // memories
    logic [63:0]          tag_hi_mem [ENTRIES];
    logic [63:0]          tag_lo_mem [ENTRIES];
    logic [TIME_BITS-1:0] sent_mem   [ENTRIES];
    logic [TIME_BITS-1:0] ans_mem    [ENTRIES];
    logic [63:0]          tag_hi_q, tag_lo_q;
    logic [TIME_BITS-1:0] sent_q;
    logic [IW-1:0]        raddr, waddr, q_addr_reg;
    logic                 tag_we, sent_we, ans_we;
    logic [TIME_BITS-1:0] ans_wdata;

    // result
    logic                 out_valid_reg;
    logic                 r_acc, r_match, r_seqo, r_has;
    logic [IW-1:0]        r_idx;
    logic [3:0]           r_idx_out;
    logic [1:0]           r_kind;
    logic [OUT_BYTES*8-1:0] out_data_reg;
    logic [TIME_BITS-1:0] rs_q, ra_q;
    logic [2:0]           r_state;
    logic [31:0]          r_trip;
    logic [TIME_BITS-1:0] diff;
    logic [OUT_BYTES*8-1:0] result_word;
    logic                 load_out;

    // decode captured word
    logic seq_ok, sel_ok, is_echo, is_err, limit_ok;
    logic [CW-1:0] send_limit;
    always_comb
    begin
        seq_ok  = {16'd0, seq_reg} < 32'(ENTRIES);
        sel_ok  = {28'd0, sel_reg} < 32'(ENTRIES);
        is_echo = typ_reg == TYPE_ECHO_REPLY && code_reg == 8'd0;
        is_err  = typ_reg == TYPE3 || typ_reg == TYPE5 || typ_reg == TYPE11
                  || typ_reg == TYPE12;
        send_limit = (32'(packet_count_reg) > 32'(ENTRIES)) ? CW'(ENTRIES)
                                                             : CW'(packet_count_reg);
        limit_ok = next_index_reg < send_limit;
    end

    logic scan_op;
    assign scan_op = op_reg == OP_TICK ||
                     (op_reg == OP_REPLY && !is_echo && is_err && len_reg >= TAG_BYTES_MIN);

    // scan pointer / direct address
    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] direct_addr;
    always_comb
    begin
        case (op_reg)
            OP_SEND:  direct_addr = next_index_reg[IW-1:0];
            OP_READ:  direct_addr = sel_reg[IW-1:0];
            default:  direct_addr = seq_reg[IW-1:0];
        endcase
    end
    assign raddr = scan_op ? ptr_reg : direct_addr;

    always_ff @(posedge clk)
    begin
        tag_hi_q   <= tag_hi_mem[raddr];
        tag_lo_q   <= tag_lo_mem[raddr];
        sent_q     <= sent_mem[raddr];
        q_addr_reg <= raddr;
        if (tag_we)
        begin
            tag_hi_mem[waddr] <= ghi_reg;
            tag_lo_mem[waddr] <= glo_reg;
        end
        if (sent_we)
            sent_mem[waddr] <= time_now_reg;
        if (ans_we)
            ans_mem[waddr] <= ans_wdata;
    end

    // per-entry evaluation of the word read last cycle
    logic tag_eq, q_sent, q_expired;
    logic [TIME_BITS-1:0] age;
    always_comb
    begin
        tag_eq    = tag_hi_q == ghi_reg && tag_lo_q == glo_reg;
        q_sent    = status_reg[q_addr_reg] == ST_SENT;
        age       = time_now_reg - sent_q;
        q_expired = age > TIME_BITS'(timeout_reg);
    end

    logic pending;
    always_comb
    begin
        pending = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (status_reg[i] == ST_SENT)
                pending = 1'b1;
    end

    logic accept_in;
    assign s_axis_tready = state_reg == S_IDLE;
    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign load_out      = state_reg == S_DONE && (!out_valid_reg || m_axis_tready);

    // memory write controls (combinational from state)
    always_comb
    begin
        tag_we = 1'b0; sent_we = 1'b0; ans_we = 1'b0;
        waddr = q_addr_reg;
        ans_wdata = time_now_reg;
        if (state_reg == S_EXEC)
        begin
            if (op_reg == OP_SEND && limit_ok && time_now_reg >= next_send_reg)
            begin
                tag_we = 1'b1; sent_we = 1'b1;
            end
            else if (op_reg == OP_REPLY && is_echo && len_reg >= TAG_BYTES_MIN
                     && seq_ok && q_sent && tag_eq)
                ans_we = 1'b1;
            else if (op_reg == OP_REPLY && !is_echo && is_err
                     && len_reg < TAG_BYTES_MIN && len_reg >= HDR_BYTES_MIN
                     && seq_ok && q_sent)
                ans_we = 1'b1;
        end
        else if ((state_reg == S_SCAN || state_reg == S_SCAN_LAST)
                 && op_reg == OP_REPLY && !found_reg && q_sent && tag_eq)
            ans_we = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            packet_count_reg  <= 5'd4;
            send_interval_reg <= 16'd1000;
            timeout_reg       <= 16'd4000;
            time_now_reg      <= '0;
            next_send_reg     <= '0;
            next_index_reg    <= '0;
            for (int i = 0; i < ENTRIES; i++)
                status_reg[i] <= ST_UNSENT;
            out_valid_reg     <= 1'b0;
            found_reg         <= 1'b0;
            timed_reg         <= '0;
            ptr_reg           <= '0;
            r_acc <= 1'b0; r_match <= 1'b0; r_seqo <= 1'b0; r_has <= 1'b0;
            r_idx <= '0; r_kind <= KIND_ECHO;
            op_reg <= OP_TICK;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PACKET_COUNT:  packet_count_reg  <= cfg_data[4:0];
                    REG_SEND_INTERVAL: send_interval_reg <= cfg_data;
                    REG_TIMEOUT:       timeout_reg       <= cfg_data;
                    default: ;
                endcase
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        op_reg   <= op_t'(s_axis_tdata[1:0]);
                        ghi_reg  <= s_axis_tdata[65:2];
                        glo_reg  <= s_axis_tdata[129:66];
                        seq_reg  <= s_axis_tdata[145:130];
                        typ_reg  <= s_axis_tdata[153:146];
                        code_reg <= s_axis_tdata[161:154];
                        len_reg  <= s_axis_tdata[172:162];
                        sel_reg  <= s_axis_tdata[176:173];
                        ptr_reg  <= '0;
                        found_reg <= 1'b0;
                        timed_reg <= '0;
                        r_acc <= 1'b0; r_match <= 1'b0; r_seqo <= 1'b0;
                        r_has <= 1'b0; r_idx <= '0; r_kind <= KIND_ECHO;
                        if (s_axis_tdata[1:0] == OP_TICK)
                            time_now_reg <= time_now_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // address issued this cycle; data valid next
                    if (scan_op)
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= (ENTRIES == 1) ? S_SCAN_LAST : S_SCAN;
                    end
                    else
                        state_reg <= S_EXEC;
                    if (op_reg == OP_REPLY)
                        r_kind <= is_echo ? KIND_ECHO : (is_err ? KIND_ERROR : KIND_OTHER);
                end
                S_SCAN, S_SCAN_LAST:
                begin
                    if (op_reg == OP_TICK)
                    begin
                        if (q_sent && q_expired)
                        begin
                            status_reg[q_addr_reg] <= ST_TIMEOUT;
                            timed_reg <= timed_reg + 1'b1;
                        end
                    end
                    else if (!found_reg && q_sent && tag_eq)
                    begin
                        status_reg[q_addr_reg] <= ST_ERROR;
                        found_reg <= 1'b1;
                        r_match <= 1'b1; r_has <= 1'b1; r_idx <= q_addr_reg;
                    end
                    if (state_reg == S_SCAN_LAST)
                        state_reg <= S_WAIT;
                    else
                    begin
                        if (32'(ptr_reg) == ENTRIES - 1)
                            state_reg <= S_SCAN_LAST;
                        else
                            ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_EXEC:
                begin
                    case (op_reg)
                        OP_SEND:
                            if (limit_ok && time_now_reg >= next_send_reg)
                            begin
                                status_reg[q_addr_reg] <= ST_SENT;
                                next_index_reg <= next_index_reg + 1'b1;
                                next_send_reg  <= time_now_reg
                                                  + TIME_BITS'(send_interval_reg);
                                r_acc <= 1'b1; r_has <= 1'b1; r_idx <= q_addr_reg;
                            end
                        OP_REPLY:
                            if (ans_we)
                            begin
                                status_reg[q_addr_reg] <= is_echo ? ST_RECVD : ST_ERROR;
                                r_match <= is_echo;
                                r_seqo  <= !is_echo;
                                r_has <= 1'b1; r_idx <= q_addr_reg;
                            end
                        OP_READ:
                            if (sel_ok)
                            begin
                                r_has <= 1'b1; r_idx <= q_addr_reg;
                            end
                        default: ;
                    endcase
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    // r_idx and the memories are settled; the times of r_idx
                    // are read at this edge
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // wait until the previous result is gone
                    if (load_out)
                    begin
                        out_data_reg <= result_word;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result assembly: times come from a dedicated registered read of r_idx,
    // valid from S_DONE on
    always_ff @(posedge clk)
    begin
        rs_q <= sent_mem[r_idx];
        ra_q <= ans_mem[r_idx];
    end

    always_comb
    begin
        r_state = r_has ? status_reg[r_idx] : ST_UNSENT;
        diff    = ra_q - rs_q;
        r_trip  = (r_has && (r_state == ST_RECVD || r_state == ST_ERROR))
                  ? 32'(diff) : 32'd0;
        r_idx_out = r_has ? 4'(r_idx) : ((op_reg == OP_READ) ? sel_reg : 4'd0);
        result_word = '0;
        result_word[0]     = r_acc;
        result_word[1]     = r_match;
        result_word[2]     = r_seqo;
        result_word[6:3]   = r_idx_out;
        result_word[9:7]   = r_state;
        result_word[41:10] = r_trip;
        result_word[43:42] = r_kind;
        result_word[48:44] = timed_reg;
        result_word[49]    = pending;
        result_word[50]    = next_index_reg >= send_limit && !pending;
    end

    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && found_reg) |=> found_reg)
        else $error("error match lost");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(next_index_reg) <= ENTRIES)
        else $error("index overrun");

endmodule
